// File: rtl/core/afl_pkg.sv
// Package for the three-axis accelerometer low-pass FIR.
// Holds the sample types, the coefficient base table and the coefficient function.
// No dependencies.
package afl_pkg;

    localparam int AXES       = 3;
    localparam int SAMPLE_W   = 16;
    localparam int BASE_COUNT = 9;

    // Coefficient base values in units of 1e-4, edge toward center.
    localparam longint BASE_E4 [BASE_COUNT] = '{
        64'sd137, 64'sd140, 64'sd142, 64'sd144, 64'sd146,
        64'sd147, 64'sd148, 64'sd149, 64'sd150
    };

    typedef logic [SAMPLE_W-1:0]           sample_t;
    typedef logic [AXES-1:0][SAMPLE_W-1:0] sample_vec_t;

    // Symmetric tap coefficient, base * 2^frac / 1e4, rounded half away from zero.
    // Evaluated at elaboration only.
    function automatic longint coef_of_tap(input int k, input int taps, input int frac);
        int     m;
        int     idx;
        longint scaled;
        m   = taps - 1 - k;
        idx = (k < m) ? k : m;
        if (idx < 0) begin
            idx = 0;
        end
        if (idx >= BASE_COUNT) begin
            idx = BASE_COUNT - 1;
        end
        scaled = BASE_E4[idx] * (longint'(1) << frac);
        return (scaled + 64'sd5000) / 64'sd10000;
    endfunction

endpackage

// File: rtl/core/accel_fir_lowpass_unit.sv
// Three-axis accelerometer low-pass FIR, TAPS taps, symmetric fixed coefficients.
// Top level: transposed chain of afl_cell taps and the afl_out result stage.
// Depends on afl_pkg, afl_cell, afl_out.
//
// Usage:
//   s_ channel: one item = one 3-axis sample (x, y, z signed 16-bit).
//   m_ channel: one item = one filtered 3-axis result per input item.
//   Each result is sum(coef[k] * sample[n-k]) / 2^COEF_FRAC_BITS, truncated
//   toward zero and saturated to 16 bits.
// Structure: a row of TAPS tap cells, each holding one partial sum per axis.
//   On every accepted item each cell adds coef[k] * new sample to the partial
//   sum from its right neighbor; tap 0's register holds the full sum.
// Output: the result is valid on m_ in the cycle after the input is accepted.
// Throughput: one item per cycle while m_tready stays high; the rate is set
//   by the single multiply-add per tap cell between registers.
// Stall: s_tready is low while a result waits and m_tready is low; the cells
//   advance only on acceptance, so the waiting result holds steady.
// Reset: aresetn low clears all partial sums (delay lines read as zeros) and
//   the result valid flag.
module accel_fir_lowpass_unit #(
    parameter int TAPS           = 19,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [15:0] filtered_x, [31:16] filtered_y, [47:32] filtered_z
);
    import afl_pkg::*;

    // coefficients stay below 2^(F-6), so F-5 signed bits hold them
    localparam int CW = COEF_FRAC_BITS - 5;
    // sum of TAPS products of 16 x CW bits, plus a guard bit
    localparam int AW = SAMPLE_W + CW + $clog2(TAPS) + 1;

    logic                    accept;
    sample_vec_t             samples;
    sample_vec_t             filtered;
    logic [AXES-1:0][AW-1:0] chain [TAPS+1];

    assign samples  = s_tdata;
    assign s_tready = !m_tvalid || m_tready;
    assign accept   = s_tvalid && s_tready;

    // right end of the chain feeds zero into the last tap
    assign chain[TAPS] = '0;

    for (genvar k = 0; k < TAPS; k++) begin : g_tap
        afl_cell #(
            .K              (k),
            .TAPS           (TAPS),
            .COEF_FRAC_BITS (COEF_FRAC_BITS),
            .CW             (CW),
            .AW             (AW)
        ) u_tap (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (accept),
            .sample_i (samples),
            .sum_i    (chain[k+1]),
            .sum_o    (chain[k])
        );
    end

    afl_out #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .AW             (AW)
    ) u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .take     (m_tready),
        .acc_i    (chain[0]),
        .valid_o  (m_tvalid),
        .result_o (filtered)
    );

    assign m_tdata = filtered;

`ifndef ASSERT_OFF
    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted item produced no result");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result slot");

    a_no_accept_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !accept)
        else $error("item accepted while result stalled");

    a_sum_held_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(chain[1]))
        else $error("tap partial sum moved without an accepted item");

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule

// File: rtl/core/afl_cell.sv
// One tap of the transposed FIR, three axes wide.
// Partial sum: coef[K] * sample + partial sum of the next tap, registered.
// Depends on afl_pkg.
module afl_cell #(
    parameter int K              = 0,
    parameter int TAPS           = 19,
    parameter int COEF_FRAC_BITS = 16,
    parameter int CW             = 11,
    parameter int AW             = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  afl_pkg::sample_vec_t                   sample_i,
    input  logic [afl_pkg::AXES-1:0][AW-1:0]       sum_i,
    output logic [afl_pkg::AXES-1:0][AW-1:0]       sum_o
);
    import afl_pkg::*;

    localparam logic signed [CW-1:0] COEF = CW'(coef_of_tap(K, TAPS, COEF_FRAC_BITS));
    localparam int PW = SAMPLE_W + CW;

    logic [AXES-1:0][AW-1:0] sum_reg;
    logic [AXES-1:0][AW-1:0] sum_next;
    logic signed [PW-1:0]    prod [AXES];

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            prod[a]     = $signed(sample_i[a]) * COEF;
            sum_next[a] = AW'($signed(sum_i[a]) + AW'(prod[a]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (en) begin
            sum_reg <= sum_next;
        end
    end

    assign sum_o = sum_reg;

endmodule

// File: rtl/core/afl_out.sv
// Result stage: valid flag, truncation toward zero and 16-bit saturation.
// Reads the full-width sum held in tap 0. Depends on afl_pkg.
module afl_out #(
    parameter int COEF_FRAC_BITS = 16,
    parameter int AW             = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             load,
    input  logic                             take,
    input  logic [afl_pkg::AXES-1:0][AW-1:0] acc_i,
    output logic                             valid_o,
    output afl_pkg::sample_vec_t             result_o
);
    import afl_pkg::*;

    localparam logic signed [AW-1:0] BIAS   = AW'((longint'(1) << COEF_FRAC_BITS) - 1);
    localparam logic signed [AW-1:0] SAT_HI = AW'(32767);
    localparam logic signed [AW-1:0] SAT_LO = -AW'(32768);

    logic                 valid_reg;
    logic                 valid_next;
    logic signed [AW-1:0] biased [AXES];
    logic signed [AW-1:0] quot   [AXES];

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            // negative sums get 2^F-1 added so the shift rounds toward zero
            biased[a] = $signed(acc_i[a]) + (acc_i[a][AW-1] ? BIAS : '0);
            quot[a]   = biased[a] >>> COEF_FRAC_BITS;
            if (quot[a] > SAT_HI) begin
                result_o[a] = SAMPLE_W'(SAT_HI);
            end else if (quot[a] < SAT_LO) begin
                result_o[a] = SAMPLE_W'(SAT_LO);
            end else begin
                result_o[a] = quot[a][SAMPLE_W-1:0];
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign valid_o = valid_reg;

endmodule
